### design/adc_pkg.sv
`default_nettype none

package adc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [2:0] {
      MODE_CLOSED    = 3'd0,
      MODE_OPENING   = 3'd1,
      MODE_OPEN      = 3'd2,
      MODE_CLOSING   = 3'd3,
      MODE_EMERGENCY = 3'd4
   } door_mode_type;

   typedef enum logic [1:0] {
      CMD_UPDATE      = 2'd0,
      CMD_MANUAL_OPEN = 2'd1,
      CMD_SET_EMERG   = 2'd2,
      CMD_CLEAR_EMERG = 2'd3
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] REG_CLOSED_ANGLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OPEN_ANGLE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DETECT_DISTANCE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_OPEN        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_INTERVAL    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BUTTON_ENABLE    = 3'd6;

   localparam logic [7:0]  CLOSED_ANGLE_RST    = 8'd0;
   localparam logic [7:0]  OPEN_ANGLE_RST      = 8'd90;
   localparam logic [8:0]  DETECT_DISTANCE_RST = 9'd50;
   localparam logic [15:0] HOLD_OPEN_RST       = 16'd5000;
   localparam logic [15:0] DEBOUNCE_RST        = 16'd50;
   localparam logic [15:0] STEP_INTERVAL_RST   = 16'd15;
   localparam logic        BUTTON_ENABLE_RST   = 1'b1;

   localparam logic [14:0] ECHO_TIMEOUT_US = 15'd30000;
   localparam logic [19:0] CM_PER_US_NUM   = 20'd17;
   localparam logic [19:0] CM_PER_US_DEN   = 20'd1000;

   localparam logic [15:0] CLIENTS_MAX = 16'hFFFF;

endpackage

`default_nettype wire

### design/auto_door_controller.sv
// Pipeline: a request passes the input register, then the result register, before its result
// is valid; the state update is one combinational pass between them.
// Throughput: one request per cycle; the result register stalls the input register only
// when a result is waiting and rsp_ready is low.
// Reset: synchronous, active high; door closed at the reset closed angle, counters and
// timestamps cleared, configuration registers at their reset values, both stages empty.
`default_nettype none

module auto_door_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [31:0]                       req_now_ms,
   input  wire logic                              req_button_level,
   input  wire logic [14:0]                       req_echo_width_us,
   input  wire logic                              req_emergency,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_door_state,
   output logic [7:0]                             rsp_servo_angle,
   output logic [15:0]                            rsp_client_count,

   input  wire logic                              csr_we,
   input  wire logic [adc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [adc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [7:0]  closed_angle_ff;
   logic [7:0]  open_angle_ff;
   logic [8:0]  detect_distance_ff;
   logic [15:0] hold_open_ff;
   logic [15:0] debounce_ff;
   logic [15:0] step_interval_ff;
   logic        button_enable_ff;

   logic                 in_valid_ff;
   adc_pkg::cmd_type     req_cmd_ff;
   logic [31:0]          req_now_ff;
   logic                 req_button_level_ff;
   logic [14:0]          req_echo_width_ff;
   logic                 req_emergency_ff;

   adc_pkg::door_mode_type door_mode_ff, door_mode_in;
   logic [7:0]   angle_ff, angle_in;
   logic [31:0]  open_since_ff, open_since_in;
   logic [31:0]  last_step_ff, last_step_in;
   logic         btn_level_ff, btn_level_in;
   logic [31:0]  btn_change_ff, btn_change_in;
   logic [15:0]  clients_ff, clients_in;

   logic         rsp_valid_ff;
   logic [2:0]   rsp_door_state_ff;
   logic [7:0]   rsp_servo_angle_ff;
   logic [15:0]  rsp_client_count_ff;

   logic         out_ok;
   logic         advance;

   logic         btn_changed;
   logic [31:0]  btn_change_eff;
   logic [31:0]  btn_delta;
   logic         pressed;
   logic [19:0]  echo_scaled;
   logic [9:0]   detect_plus_one;
   logic [19:0]  echo_limit;
   logic         client_present;
   logic [15:0]  clients_inc;
   logic [7:0]   step_target;
   logic         step_ok;
   logic [7:0]   angle_step;
   logic         target_reached;
   logic [31:0]  open_since_eff;
   logic         hold_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_angle_ff    <= adc_pkg::CLOSED_ANGLE_RST;
         open_angle_ff      <= adc_pkg::OPEN_ANGLE_RST;
         detect_distance_ff <= adc_pkg::DETECT_DISTANCE_RST;
         hold_open_ff       <= adc_pkg::HOLD_OPEN_RST;
         debounce_ff        <= adc_pkg::DEBOUNCE_RST;
         step_interval_ff   <= adc_pkg::STEP_INTERVAL_RST;
         button_enable_ff   <= adc_pkg::BUTTON_ENABLE_RST;
      end else if (csr_we) begin
         case (csr_index)
            adc_pkg::REG_CLOSED_ANGLE:    closed_angle_ff    <= csr_wdata[7:0];
            adc_pkg::REG_OPEN_ANGLE:      open_angle_ff      <= csr_wdata[7:0];
            adc_pkg::REG_DETECT_DISTANCE: detect_distance_ff <= csr_wdata[8:0];
            adc_pkg::REG_HOLD_OPEN:       hold_open_ff       <= csr_wdata;
            adc_pkg::REG_DEBOUNCE:        debounce_ff        <= csr_wdata;
            adc_pkg::REG_STEP_INTERVAL:   step_interval_ff   <= csr_wdata;
            adc_pkg::REG_BUTTON_ENABLE:   button_enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign out_ok    = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_ok;
   assign req_ready = !in_valid_ff || out_ok;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_cmd_ff          <= adc_pkg::cmd_type'(req_cmd);
         req_now_ff          <= req_now_ms;
         req_button_level_ff <= req_button_level;
         req_echo_width_ff   <= req_echo_width_us;
         req_emergency_ff    <= req_emergency;
      end
   end

   // button debounce
   assign btn_changed    = req_button_level_ff != btn_level_ff;
   assign btn_change_eff = btn_changed ? req_now_ff : btn_change_ff;
   assign btn_delta      = req_now_ff - btn_change_eff;
   assign pressed        = button_enable_ff && !req_button_level_ff
                           && (btn_delta > {16'b0, debounce_ff});

   // distance check: 1 <= floor(w*17/1000) <= detect  <=>  1000 <= w*17 < (detect+1)*1000
   assign echo_scaled     = {5'b0, req_echo_width_ff} * adc_pkg::CM_PER_US_NUM;
   assign detect_plus_one = {1'b0, detect_distance_ff} + 10'd1;
   assign echo_limit      = {10'b0, detect_plus_one} * adc_pkg::CM_PER_US_DEN;
   assign client_present  = (req_echo_width_ff != 15'd0)
                            && (req_echo_width_ff <= adc_pkg::ECHO_TIMEOUT_US)
                            && (echo_scaled >= adc_pkg::CM_PER_US_DEN)
                            && (echo_scaled < echo_limit);

   assign clients_inc = (clients_ff == adc_pkg::CLIENTS_MAX) ? clients_ff
                                                             : clients_ff + 16'd1;

   // servo step toward the target of the current motion
   assign step_target = (door_mode_ff == adc_pkg::MODE_OPENING) ? open_angle_ff
                                                                : closed_angle_ff;
   assign step_ok     = (req_now_ff - last_step_ff) >= {16'b0, step_interval_ff};
   always_comb begin
      if (angle_ff < step_target) begin
         angle_step = angle_ff + 8'd1;
      end else if (angle_ff > step_target) begin
         angle_step = angle_ff - 8'd1;
      end else begin
         angle_step = angle_ff;
      end
   end
   assign target_reached = step_ok && (angle_step == step_target);

   assign open_since_eff = pressed ? req_now_ff : open_since_ff;
   assign hold_done      = (req_now_ff - open_since_eff) >= {16'b0, hold_open_ff};

   // next door state
   always_comb begin
      door_mode_in  = door_mode_ff;
      angle_in      = angle_ff;
      open_since_in = open_since_ff;
      last_step_in  = last_step_ff;
      btn_level_in  = btn_level_ff;
      btn_change_in = btn_change_ff;
      clients_in    = clients_ff;
      case (req_cmd_ff)
         adc_pkg::CMD_UPDATE: begin
            if (button_enable_ff) begin
               btn_level_in  = pressed ? 1'b1 : req_button_level_ff;
               btn_change_in = btn_change_eff;
            end
            if (door_mode_ff != adc_pkg::MODE_EMERGENCY) begin
               if (req_emergency_ff) begin
                  door_mode_in = adc_pkg::MODE_EMERGENCY;
               end else begin
                  case (door_mode_ff)
                     adc_pkg::MODE_CLOSED: begin
                        if (client_present || pressed) begin
                           clients_in   = clients_inc;
                           door_mode_in = adc_pkg::MODE_OPENING;
                        end
                     end
                     adc_pkg::MODE_OPENING: begin
                        if (step_ok) begin
                           last_step_in = req_now_ff;
                           angle_in     = angle_step;
                        end
                        if (target_reached) begin
                           door_mode_in  = adc_pkg::MODE_OPEN;
                           open_since_in = req_now_ff;
                        end
                     end
                     adc_pkg::MODE_OPEN: begin
                        open_since_in = open_since_eff;
                        if (hold_done) begin
                           door_mode_in = adc_pkg::MODE_CLOSING;
                        end
                     end
                     adc_pkg::MODE_CLOSING: begin
                        if (pressed) begin
                           door_mode_in = adc_pkg::MODE_OPENING;
                        end else begin
                           if (step_ok) begin
                              last_step_in = req_now_ff;
                              angle_in     = angle_step;
                           end
                           if (target_reached) begin
                              door_mode_in = adc_pkg::MODE_CLOSED;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         adc_pkg::CMD_MANUAL_OPEN: begin
            if (door_mode_ff == adc_pkg::MODE_CLOSED
                || door_mode_ff == adc_pkg::MODE_CLOSING) begin
               clients_in   = clients_inc;
               door_mode_in = adc_pkg::MODE_OPENING;
            end
         end
         adc_pkg::CMD_SET_EMERG: begin
            door_mode_in = adc_pkg::MODE_EMERGENCY;
         end
         adc_pkg::CMD_CLEAR_EMERG: begin
            angle_in     = closed_angle_ff;
            door_mode_in = adc_pkg::MODE_CLOSED;
         end
         default: ;
      endcase
   end

   // door state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         door_mode_ff  <= adc_pkg::MODE_CLOSED;
         angle_ff      <= adc_pkg::CLOSED_ANGLE_RST;
         open_since_ff <= 32'd0;
         last_step_ff  <= 32'd0;
         btn_level_ff  <= 1'b1;
         btn_change_ff <= 32'd0;
         clients_ff    <= 16'd0;
      end else if (advance) begin
         door_mode_ff  <= door_mode_in;
         angle_ff      <= angle_in;
         open_since_ff <= open_since_in;
         last_step_ff  <= last_step_in;
         btn_level_ff  <= btn_level_in;
         btn_change_ff <= btn_change_in;
         clients_ff    <= clients_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ok) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_door_state_ff   <= door_mode_in;
         rsp_servo_angle_ff  <= angle_in;
         rsp_client_count_ff <= clients_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_door_state   = rsp_door_state_ff;
   assign rsp_servo_angle  = rsp_servo_angle_ff;
   assign rsp_client_count = rsp_client_count_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("transfer into result register lost");

   a_clients_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> clients_ff >= $past(clients_ff))
      else $error("client counter decreased");

   a_angle_single_step: assert property (@(posedge clock) disable iff (reset)
      advance && req_cmd_ff != adc_pkg::CMD_CLEAR_EMERG |=>
         (angle_ff == $past(angle_ff) || angle_ff == $past(angle_ff) + 8'd1
          || angle_ff == $past(angle_ff) - 8'd1))
      else $error("servo angle moved more than one degree");

   a_emergency_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && door_mode_ff == adc_pkg::MODE_EMERGENCY
         && req_cmd_ff != adc_pkg::CMD_CLEAR_EMERG
      |=> door_mode_ff == adc_pkg::MODE_EMERGENCY)
      else $error("emergency left without clear command");

endmodule

`default_nettype wire
